// ----- rtl/assert_macros.svh -----
// assertion macros shared by the box filter rtl
// no dependencies; clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BFM_ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);
`else
`define BFM_ASSERT(lbl, prop, msg)
`define BFM_ASSERT_NEVER(lbl, prop, msg)
`endif
`endif

// ----- rtl/bfm_pkg.sv -----
// package of the 7x7 box filter: widths, register indexes and shared types
// no dependencies
package bfm_pkg;

  localparam int unsigned MAX_WIDTH     = 512;
  localparam int unsigned MAX_HEIGHT    = 512;
  localparam int unsigned WINDOW_RADIUS = 3;
  localparam int unsigned DIAM          = 2 * WINDOW_RADIUS + 1;
  localparam int unsigned LINES         = 2 * WINDOW_RADIUS;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned DIM_W  = 10;
  localparam int unsigned POS_W  = 9;
  localparam int unsigned ADDR_W = $clog2(MAX_WIDTH);
  localparam int unsigned SLOT_W = $clog2(LINES);
  localparam int unsigned WORD_W = LINES * PIX_W;
  localparam int unsigned CSUM_W = 11;
  localparam int unsigned WSUM_W = 14;

  // floor(x / 49) = (x * 21400) >> 20 for every window sum
  localparam int unsigned MUL_W     = 15;
  localparam int unsigned DIV_SHIFT = 20;
  localparam logic [MUL_W-1:0] DIV_MUL = MUL_W'(21400);
  localparam int unsigned PROD_W    = WSUM_W + MUL_W;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);
  localparam logic [DIM_W-1:0]     DIM_RESET        = DIM_W'(512);

  typedef struct packed {
    logic [ADDR_W-1:0] col;
    logic [SLOT_W-1:0] slot;
    logic [PIX_W-1:0]  pix;
  } bfm_lane_t;

  typedef struct packed {
    logic             present;
    logic             interior;
    logic             first_col;
    logic             frame_last;
    logic [POS_W-1:0] centre_row;
    logic [POS_W-1:0] centre_column;
  } bfm_meta_t;

  typedef struct packed {
    logic [POS_W-1:0] centre_row;
    logic [POS_W-1:0] centre_column;
    logic [PIX_W-1:0] mean_value;
    logic             centre_present;
    logic             frame_last;
  } bfm_res_t;

endpackage

// ----- rtl/bfm_if.sv -----
// stream interfaces of the box filter: pixel in, result out, config write
// depends on bfm_pkg
interface bfm_pix_if;
  logic                       valid;
  logic                       ready;
  logic [bfm_pkg::PIX_W-1:0]  pixel_value;
  logic                       frame_start;
  modport source (output valid, pixel_value, frame_start, input ready);
  modport sink   (input valid, pixel_value, frame_start, output ready);
endinterface

interface bfm_res_if;
  logic                       valid;
  logic                       ready;
  logic [bfm_pkg::POS_W-1:0]  centre_row;
  logic [bfm_pkg::POS_W-1:0]  centre_column;
  logic [bfm_pkg::PIX_W-1:0]  mean_value;
  logic                       centre_present;
  logic                       frame_last;
  modport source (output valid, centre_row, centre_column, mean_value, centre_present,
                  frame_last, input ready);
  modport sink   (input valid, centre_row, centre_column, mean_value, centre_present,
                  frame_last, output ready);
endinterface

interface bfm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bfm_pkg::CFG_IDX_W-1:0] index;
  logic [bfm_pkg::DIM_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/box_filter_7x7_mean.sv -----
// 7x7 box mean filter over a raster pixel stream
// usage:
//   pix_i takes one 8-bit pixel per word in raster order; frame_start marks
//   row 0, column 0 of a frame. res_o gives one word per pixel for the
//   centre three rows and three columns back: its position, the window sum
//   over 49 truncated (zero on the three-pixel border), a present flag that
//   is low while no centre is formed yet, and frame_last on the last pixel.
//   cfg_i writes image_width (index 0) and image_height (index 1), both
//   clamped to 7..512; write them only while the block is idle.
// throughput: one pixel per clock while the skid entry is empty, set by
//   the single read-modify-write of the line store word for each column.
// pipeline: a pixel is registered through the store read, column sum,
//   window sum, multiply and output register stages into its result.
// reset: positions and the window clear at once, both sizes go to 512; the
//   line store is not cleared and is filled by the first six rows.
// stall: a two-entry output register plus skid keeps pix_i ready while one
//   result waits; the pipeline holds only when both entries are full.
`include "assert_macros.svh"

module box_filter_7x7_mean (
  input  logic clk_i,
  input  logic rst_ni,
  bfm_pix_if.sink   pix_i,
  bfm_res_if.source res_o,
  bfm_cfg_if.sink   cfg_i
);
  import bfm_pkg::*;

  logic [DIM_W-1:0] width_q, width_d, height_q, height_d;
  logic             adv, accept, take;
  bfm_lane_t        lane0, s1_lane_q;
  bfm_meta_t        meta0, s1_meta_q, s2_meta_q, s3_meta_q, s4_meta_q;
  logic             s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic [WORD_W-1:0] rd_word, wr_word;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [WSUM_W-1:0] wsum;
  logic [PIX_W-1:0]  mean;
  bfm_res_t          res_new, out_q, out_d, skid_q, skid_d;
  logic              out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_IMAGE_WIDTH:  width_d  = cfg_i.data;
        CFG_IMAGE_HEIGHT: height_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // pipeline control
  assign adv         = !skid_valid_q;
  assign pix_i.ready = adv;
  assign accept      = pix_i.valid && adv;
  assign take        = out_valid_q && res_o.ready;

  bfm_position u_pos (
    .clk_i,
    .rst_ni,
    .accept_i      (accept),
    .frame_start_i (pix_i.frame_start),
    .pixel_value_i (pix_i.pixel_value),
    .width_i       (width_q),
    .height_i      (height_q),
    .lane_o        (lane0),
    .meta_o        (meta0)
  );

  bfm_line_ram u_ram (
    .clk_i,
    .rd_en_i   (accept),
    .rd_addr_i (lane0.col),
    .rd_word_o (rd_word),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_word_i (wr_word)
  );

  bfm_window u_win (
    .clk_i,
    .rst_ni,
    .adv_i       (adv),
    .valid_i     (s1_valid_q),
    .lane_i      (s1_lane_q),
    .first_col_i (s1_meta_q.first_col),
    .rd_word_i   (rd_word),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_word_o   (wr_word),
    .wsum_o      (wsum)
  );

  bfm_divide u_div (
    .clk_i,
    .adv_i  (adv),
    .wsum_i (wsum),
    .mean_o (mean)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_lane_q <= lane0;
      s1_meta_q <= meta0;
      s2_meta_q <= s1_meta_q;
      s3_meta_q <= s2_meta_q;
      s4_meta_q <= s3_meta_q;
    end
  end

  // output register and skid
  always_comb begin
    res_new.centre_row     = s4_meta_q.centre_row;
    res_new.centre_column  = s4_meta_q.centre_column;
    res_new.mean_value     = s4_meta_q.interior ? mean : '0;
    res_new.centre_present = s4_meta_q.present;
    res_new.frame_last     = s4_meta_q.frame_last;
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else begin
      if (take) begin
        out_valid_d = 1'b0;
      end
      if (s4_valid_q) begin
        if (!out_valid_q || take) begin
          out_d       = res_new;
          out_valid_d = 1'b1;
        end else begin
          skid_d       = res_new;
          skid_valid_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.centre_row     = out_q.centre_row;
  assign res_o.centre_column  = out_q.centre_column;
  assign res_o.mean_value     = out_q.mean_value;
  assign res_o.centre_present = out_q.centre_present;
  assign res_o.frame_last     = out_q.frame_last;

  `BFM_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid full with empty output")
  `BFM_ASSERT(a_skid_holds, skid_valid_q && !take |=> skid_valid_q && $stable(skid_q), "skid word lost")
  `BFM_ASSERT_NEVER(a_mean_needs_centre, out_valid_q && out_q.mean_value != '0 && !out_q.centre_present, "mean on absent centre")
  `BFM_ASSERT_NEVER(a_absent_zero_pos, out_valid_q && !out_q.centre_present && (out_q.centre_row != '0 || out_q.centre_column != '0), "absent centre with position")

endmodule

// ----- rtl/bfm_line_ram.sv -----
// line store: one word per column holding six stored lines of pixels
// depends on bfm_pkg; one write and one registered read port
module bfm_line_ram (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [bfm_pkg::ADDR_W-1:0]   rd_addr_i,
  output logic [bfm_pkg::WORD_W-1:0]   rd_word_o,
  input  logic                         wr_en_i,
  input  logic [bfm_pkg::ADDR_W-1:0]   wr_addr_i,
  input  logic [bfm_pkg::WORD_W-1:0]   wr_word_i
);
  import bfm_pkg::*;

  logic [WORD_W-1:0] mem [MAX_WIDTH];
  logic [WORD_W-1:0] rd_word_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_word_q <= mem[rd_addr_i];
    end
  end

  assign rd_word_o = rd_word_q;

endmodule

// ----- rtl/bfm_position.sv -----
// raster position tracking: row, column and line slot of the incoming pixel
// depends on bfm_pkg; gives the memory lane and the result tags per word
module bfm_position (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic                       frame_start_i,
  input  logic [bfm_pkg::PIX_W-1:0]  pixel_value_i,
  input  logic [bfm_pkg::DIM_W-1:0]  width_i,
  input  logic [bfm_pkg::DIM_W-1:0]  height_i,
  output bfm_pkg::bfm_lane_t         lane_o,
  output bfm_pkg::bfm_meta_t         meta_o
);
  import bfm_pkg::*;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    if (v < DIM_W'(DIAM)) begin
      return DIM_W'(DIAM);
    end else if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  logic [POS_W-1:0]  row_q;
  logic [DIM_W-1:0]  col_q;
  logic [SLOT_W-1:0] slot_q;
  logic [DIM_W-1:0]  w, h, row0, col0, row1, col1, row_c, col_c;
  logic [SLOT_W-1:0] slot0, slot1;
  logic              present;

  always_comb begin
    w     = clamp_dim(width_i, DIM_W'(MAX_WIDTH));
    h     = clamp_dim(height_i, DIM_W'(MAX_HEIGHT));
    row0  = frame_start_i ? '0 : {1'b0, row_q};
    col0  = frame_start_i ? '0 : col_q;
    slot0 = frame_start_i ? '0 : slot_q;
    row1  = row0;
    col1  = col0;
    slot1 = slot0;
    if (col0 >= w) begin
      col1  = '0;
      row1  = row0 + DIM_W'(1);
      slot1 = (slot0 == SLOT_W'(LINES - 1)) ? '0 : slot0 + SLOT_W'(1);
    end
    if (row1 >= h) begin
      row1  = '0;
      slot1 = '0;
    end
    row_c   = row1 - DIM_W'(WINDOW_RADIUS);
    col_c   = col1 - DIM_W'(WINDOW_RADIUS);
    present = (row1 >= DIM_W'(WINDOW_RADIUS)) && (col1 >= DIM_W'(WINDOW_RADIUS));

    lane_o.col  = col1[ADDR_W-1:0];
    lane_o.slot = slot1;
    lane_o.pix  = pixel_value_i;

    meta_o.present       = present;
    meta_o.interior      = (row1 >= DIM_W'(LINES)) && (col1 >= DIM_W'(LINES));
    meta_o.first_col     = (col1 == '0);
    meta_o.frame_last    = (row1 == h - DIM_W'(1)) && (col1 == w - DIM_W'(1));
    meta_o.centre_row    = present ? row_c[POS_W-1:0] : '0;
    meta_o.centre_column = present ? col_c[POS_W-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      slot_q <= '0;
    end else if (accept_i) begin
      row_q  <= row1[POS_W-1:0];
      col_q  <= col1 + DIM_W'(1);
      slot_q <= slot1;
    end
  end

endmodule

// ----- rtl/bfm_window.sv -----
// column sums and the sliding seven-column window sum
// depends on bfm_pkg; modifies the line store word read by the top level
module bfm_window (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        valid_i,
  input  bfm_pkg::bfm_lane_t          lane_i,
  input  logic                        first_col_i,
  input  logic [bfm_pkg::WORD_W-1:0]  rd_word_i,
  output logic                        wr_en_o,
  output logic [bfm_pkg::ADDR_W-1:0]  wr_addr_o,
  output logic [bfm_pkg::WORD_W-1:0]  wr_word_o,
  output logic [bfm_pkg::WSUM_W-1:0]  wsum_o
);
  import bfm_pkg::*;

  logic              fwd_valid_q;
  logic [ADDR_W-1:0] fwd_addr_q;
  logic [WORD_W-1:0] fwd_word_q;
  logic [WORD_W-1:0] word, new_word;
  logic [CSUM_W-1:0] colsum, csum_q;
  logic              s2_valid_q, s2_first_q;
  logic [CSUM_W-1:0] cw_q [DIAM];
  logic [WSUM_W-1:0] wsum_q;

  // the previous word's write lands on the same edge as this word's read
  always_comb begin
    word     = (fwd_valid_q && fwd_addr_q == lane_i.col) ? fwd_word_q : rd_word_i;
    colsum   = CSUM_W'(lane_i.pix);
    new_word = word;
    for (int k = 0; k < LINES; k++) begin
      colsum = colsum + CSUM_W'(word[k*PIX_W +: PIX_W]);
      if (lane_i.slot == SLOT_W'(k)) begin
        new_word[k*PIX_W +: PIX_W] = lane_i.pix;
      end
    end
  end

  assign wr_en_o   = adv_i && valid_i;
  assign wr_addr_o = lane_i.col;
  assign wr_word_o = new_word;
  assign wsum_o    = wsum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
      s2_valid_q  <= 1'b0;
    end else if (adv_i) begin
      fwd_valid_q <= valid_i;
      s2_valid_q  <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      fwd_addr_q <= lane_i.col;
      fwd_word_q <= new_word;
      csum_q     <= colsum;
      s2_first_q <= first_col_i;
    end
  end

  // window cleared at the start of each row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIAM; k++) begin
        cw_q[k] <= '0;
      end
      wsum_q <= '0;
    end else if (adv_i && s2_valid_q) begin
      if (s2_first_q) begin
        for (int k = 1; k < DIAM; k++) begin
          cw_q[k] <= '0;
        end
        wsum_q <= WSUM_W'(csum_q);
      end else begin
        for (int k = 1; k < DIAM; k++) begin
          cw_q[k] <= cw_q[k-1];
        end
        wsum_q <= wsum_q - WSUM_W'(cw_q[DIAM-1]) + WSUM_W'(csum_q);
      end
      cw_q[0] <= csum_q;
    end
  end

endmodule

// ----- rtl/bfm_divide.sv -----
// division of the window sum by 49 through a reciprocal multiply
// depends on bfm_pkg; one register stage after the multiplier
module bfm_divide (
  input  logic                        clk_i,
  input  logic                        adv_i,
  input  logic [bfm_pkg::WSUM_W-1:0]  wsum_i,
  output logic [bfm_pkg::PIX_W-1:0]   mean_o
);
  import bfm_pkg::*;

  logic [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= PROD_W'(wsum_i) * PROD_W'(DIV_MUL);
    end
  end

  assign mean_o = prod_q[DIV_SHIFT +: PIX_W];

endmodule

// ----- tb/box_filter_7x7_mean_chk.sv -----
// checker of the 7x7 box mean filter: keeps its own copy of the line store,
// column sums and sizes, predicts every result word and compares it
// depends on bfm_pkg and the stream interfaces in bfm_if
module box_filter_7x7_mean_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  bfm_pix_if          pix_i,
  bfm_res_if          res_i,
  bfm_cfg_if          cfg_i,
  output int unsigned results_seen_o,
  output int unsigned interior_seen_o,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);
  import bfm_pkg::*;

  localparam int unsigned WIN_AREA = DIAM * DIAM;

  logic [DIM_W-1:0]  width_reg  = DIM_RESET;
  logic [DIM_W-1:0]  height_reg = DIM_RESET;
  bit   [PIX_W-1:0]  line_mem [LINES][MAX_WIDTH];
  logic [CSUM_W-1:0] csum_win [DIAM];
  logic [WSUM_W-1:0] win_sum;
  int unsigned       row_pos;
  int unsigned       col_pos;
  int unsigned       mismatches;
  bfm_res_t          mean_q [$];

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
    return (v < DIAM) ? DIAM : ((v > hi) ? hi : int'(v));
  endfunction

  task automatic predict_mean(input logic [PIX_W-1:0] pix, input logic fs);
    int unsigned       w;
    int unsigned       h;
    int unsigned       row;
    int unsigned       col;
    int unsigned       k;
    logic [CSUM_W-1:0] csum;
    bfm_res_t          exp_w;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    row = row_pos;
    col = col_pos;

    // vertical sum over this pixel and the six lines above
    csum = CSUM_W'(pix);
    for (k = 0; k < LINES; k++) csum += CSUM_W'(line_mem[k][col]);
    line_mem[row % LINES][col] = pix;

    if (col == 0) begin
      csum_win = '{default: '0};
      win_sum  = '0;
    end
    win_sum -= WSUM_W'(csum_win[DIAM-1]);
    for (k = DIAM - 1; k > 0; k--) csum_win[k] = csum_win[k-1];
    csum_win[0] = csum;
    win_sum += WSUM_W'(csum);

    exp_w = '0;
    if (row >= WINDOW_RADIUS && col >= WINDOW_RADIUS) begin
      exp_w.centre_row     = POS_W'(row - WINDOW_RADIUS);
      exp_w.centre_column  = POS_W'(col - WINDOW_RADIUS);
      exp_w.centre_present = 1'b1;
      if (row >= LINES && col >= LINES) begin
        exp_w.mean_value = PIX_W'(win_sum / WIN_AREA);
        interior_seen_o <= interior_seen_o + 1;
      end
    end
    exp_w.frame_last = (row == h - 1) && (col == w - 1);
    col_pos = col + 1;
    mean_q.push_back(exp_w);
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  task automatic compare_word(input bfm_res_t exp_w);
    check_field("centre_row", 16'(exp_w.centre_row), 16'(res_i.centre_row));
    check_field("centre_column", 16'(exp_w.centre_column), 16'(res_i.centre_column));
    check_field("mean_value", 16'(exp_w.mean_value), 16'(res_i.mean_value));
    check_field("centre_present", 16'(exp_w.centre_present), 16'(res_i.centre_present));
    check_field("frame_last", 16'(exp_w.frame_last), 16'(res_i.frame_last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  = DIM_RESET;
      height_reg = DIM_RESET;
      csum_win   = '{default: '0};
      win_sum    = '0;
      row_pos    = 0;
      col_pos    = 0;
      mismatches = 0;
      mean_q.delete();
      results_seen_o  <= 0;
      interior_seen_o <= 0;
      pending_o       <= 0;
      fail_count_o    <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_IMAGE_WIDTH:  width_reg  = cfg_i.data;
          CFG_IMAGE_HEIGHT: height_reg = cfg_i.data;
          default: ;
        endcase
      end
      if (pix_i.valid && pix_i.ready) predict_mean(pix_i.pixel_value, pix_i.frame_start);
      if (res_i.valid && res_i.ready) begin
        results_seen_o <= results_seen_o + 1;
        if (mean_q.size() == 0) begin
          $error("result word with no pixel waiting for it: row %0d column %0d",
                 res_i.centre_row, res_i.centre_column);
          mismatches++;
        end else begin
          compare_word(mean_q.pop_front());
        end
      end
      pending_o    <= mean_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ----- tb/box_filter_7x7_mean_tb.sv -----
// testbench top of the 7x7 box mean filter: clock, reset, pixel and size
// stimulus with random idling and a long output hold-off, watchdog, verdict
// depends on bfm_pkg, bfm_if, box_filter_7x7_mean and box_filter_7x7_mean_chk
module box_filter_7x7_mean_tb;
  import bfm_pkg::*;

  localparam int unsigned HALF_PERIOD  = 5;
  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned WIDE_ITEMS   = MAX_WIDTH + 16;
  localparam int unsigned TALL_ITEMS   = 8 * DIAM;
  localparam int unsigned IDLE_PCT     = 12;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned STALL_LIMIT  = 5 * HOLD_CYCLES;
  localparam int unsigned TAIL_CYCLES  = 16;

  typedef enum logic [1:0] {PIX_RANDOM, PIX_FULL, PIX_ZERO, PIX_EXTREME} pix_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  bfm_pix_if pix_bus ();
  bfm_res_if res_bus ();
  bfm_cfg_if cfg_bus ();

  int unsigned idle_pct       = IDLE_PCT;
  int unsigned hold_ticket    = 0;
  int unsigned hold_taken     = 0;
  int unsigned hold_left      = 0;
  int unsigned pixels_sent    = 0;
  int unsigned random_sent    = 0;
  int unsigned settings_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned results_seen;
  int unsigned interior_seen;
  int unsigned pending;
  int unsigned fail_count;

  always #(HALF_PERIOD) clk_i = ~clk_i;

  box_filter_7x7_mean u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_bus),
    .res_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  box_filter_7x7_mean_chk u_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pix_i           (pix_bus),
    .res_i           (res_bus),
    .cfg_i           (cfg_bus),
    .results_seen_o  (results_seen),
    .interior_seen_o (interior_seen),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  // result side: random idling, or a long hold-off when one is asked for
  always @(posedge clk_i) begin
    if (hold_ticket != hold_taken) begin
      hold_taken    <= hold_ticket;
      hold_left     <= HOLD_CYCLES;
      res_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $error("no word accepted for %0d cycles", STALL_LIMIT);
      $display("box_filter_7x7_mean_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int unsigned dim_of(input logic [DIM_W-1:0] v, input int unsigned hi);
    return (v < DIAM) ? DIAM : ((v > hi) ? hi : int'(v));
  endfunction

  task automatic push_pixel(input logic [PIX_W-1:0] p, input logic fs);
    while ($urandom_range(99) < idle_pct) begin
      pix_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_bus.valid       <= 1'b1;
    pix_bus.pixel_value <= p;
    pix_bus.frame_start <= fs;
    @(posedge clk_i);
    while (!pix_bus.ready) @(posedge clk_i);
    pixels_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    while (results_seen < pixels_sent) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [DIM_W-1:0] w_data, input logic [DIM_W-1:0] h_data,
                           input int unsigned n_pix, input pix_mode_e mode);
    int unsigned      frame_len;
    int unsigned      pos;
    int unsigned      i;
    logic             fs;
    logic [PIX_W-1:0] p;
    write_reg(CFG_IMAGE_WIDTH, w_data);
    write_reg(CFG_IMAGE_HEIGHT, h_data);
    cfg_bus.valid <= 1'b0;
    frame_len = dim_of(w_data, MAX_WIDTH) * dim_of(h_data, MAX_HEIGHT);
    pos = 0;
    for (i = 0; i < n_pix; i++) begin
      fs = (pos == 0);
      // now and then drop the frame marker or restart a frame early
      if (i != 0 && fs && $urandom_range(9) == 0) fs = 1'b0;
      else if (i != 0 && !fs && $urandom_range(199) == 0) fs = 1'b1;
      if (fs) pos = 0;
      case (mode)
        PIX_FULL:    p = '1;
        PIX_ZERO:    p = '0;
        PIX_EXTREME: p = ($urandom_range(1) != 0) ? '1 : '0;
        default:     p = PIX_W'($urandom_range(255));
      endcase
      push_pixel(p, fs);
      pos = (pos + 1 == frame_len) ? 0 : pos + 1;
    end
    pix_bus.valid <= 1'b0;
    drain();
    settings_count++;
  endtask

  initial begin
    int unsigned      i;
    int unsigned      k;
    int unsigned      n;
    logic [DIM_W-1:0] w_data;
    logic [DIM_W-1:0] h_data;
    pix_bus.valid       = 1'b0;
    pix_bus.pixel_value = '0;
    pix_bus.frame_start = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = CFG_IMAGE_WIDTH;
    cfg_bus.data        = '0;
    res_bus.ready       = 1'b0;
    rst_ni              = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset sizes, first row only: extremes and a restart in mid row
    push_pixel('0, 1'b1);
    push_pixel('1, 1'b0);
    push_pixel('1, 1'b0);
    push_pixel('0, 1'b0);
    push_pixel(PIX_W'(128), 1'b1);
    for (i = 0; i < 11; i++) push_pixel(($urandom_range(1) != 0) ? '1 : '0, 1'b0);
    pix_bus.valid <= 1'b0;
    drain();
    settings_count++;

    // narrow the row below the current column, so the position wraps
    write_reg(CFG_IMAGE_WIDTH, DIM_W'(8));
    cfg_bus.valid <= 1'b0;
    for (i = 0; i < 8; i++) push_pixel(PIX_W'($urandom_range(255)), 1'b0);
    pix_bus.valid <= 1'b0;
    drain();
    settings_count++;

    k = 0;
    idle_pct = 0;
    while (random_sent < RANDOM_ITEMS) begin
      w_data = ($urandom_range(7) == 0) ? DIM_W'($urandom_range(6))
                                        : DIM_W'($urandom_range(7, 16));
      h_data = ($urandom_range(7) == 0) ? DIM_W'($urandom_range(6))
                                        : DIM_W'($urandom_range(7, 12));
      n = dim_of(w_data, MAX_WIDTH) * dim_of(h_data, MAX_HEIGHT);
      n = n + $urandom_range(n);
      if (k == 1) hold_ticket++;
      run_phase(w_data, h_data, n,
                ($urandom_range(3) == 0) ? pix_mode_e'($urandom_range(1, 3)) : PIX_RANDOM);
      random_sent += n;
      idle_pct = IDLE_PCT;
      k++;
    end

    // widest setting: a full row and the wrap into the next; tallest: first rows
    run_phase('1, DIM_W'(DIAM), WIDE_ITEMS, PIX_RANDOM);
    run_phase('0, '1, TALL_ITEMS, PIX_RANDOM);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending != 0) $error("%0d result words still expected at the end", pending);
    $display("%0d pixels over %0d size settings, 7 to 512 wide and high; %0d interior means",
             pixels_sent, settings_count, interior_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("box_filter_7x7_mean_tb OK");
    end else begin
      $display("box_filter_7x7_mean_tb NOT OK");
    end
    $finish;
  end

endmodule
